FILE: rtl/core/lppd_pkg.sv
// ----------------------------------------------------------------------------
// lppd_pkg
// Shared types, widths and constants of the line position PID drive core.
// ----------------------------------------------------------------------------
package lppd_pkg;

   localparam int SENSORS_DEF = 6;

   localparam int GAIN_W      = 16;
   localparam int SPEED_W     = 8;
   localparam int FLOOR_W     = 9;
   localparam int POS_OUT_W   = 13;
   localparam int ERR_W       = 14;
   localparam int PREV_W      = 13;
   localparam int DERIV_W     = 15;
   localparam int INTEG_W     = 24;
   localparam int MOP_W       = 25;
   localparam int MUL_W       = 42;
   localparam int ACC_W       = 44;
   localparam int CORR_W      = 36;
   localparam int SPD_W       = CORR_W + 1;
   localparam int CLAMP_W     = 11;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int DIV_BITS    = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [GAIN_W-1:0]         GAIN_PROP_RST  = 16'd640;
   localparam logic [GAIN_W-1:0]         GAIN_INTEG_RST = 16'd13;
   localparam logic [GAIN_W-1:0]         GAIN_DERIV_RST = 16'd461;
   localparam logic [SPEED_W-1:0]        BASE_RST       = 8'd255;
   localparam logic [SPEED_W-1:0]        CEILING_RST    = 8'd255;
   localparam logic signed [FLOOR_W-1:0] FLOOR_RST      = -9'sd150;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN_PROP     = 3'd0,
      CSR_GAIN_INTEG    = 3'd1,
      CSR_GAIN_DERIV    = 3'd2,
      CSR_BASE_SPEED    = 3'd3,
      CSR_SPEED_CEILING = 3'd4,
      CSR_SPEED_FLOOR   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]         gain_prop;
      logic [GAIN_W-1:0]         gain_integ;
      logic [GAIN_W-1:0]         gain_deriv;
      logic [SPEED_W-1:0]        base_speed;
      logic [SPEED_W-1:0]        speed_ceiling;
      logic signed [FLOOR_W-1:0] speed_floor;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_ERROR,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_SUM,
      ST_CORR,
      ST_DRIVE
   } back_state_type;

   typedef struct packed {
      logic               reverse;
      logic [SPEED_W-1:0] duty;
   } drive_type;

   // clamp to floor then ceiling, split into direction and magnitude
   function automatic drive_type drive_split(input logic signed [SPD_W-1:0]   s,
                                             input logic signed [FLOOR_W-1:0] lo,
                                             input logic [SPEED_W-1:0]        hi);
      logic signed [SPD_W-1:0]   lo_e;
      logic signed [SPD_W-1:0]   hi_e;
      logic signed [SPD_W-1:0]   c;
      logic signed [CLAMP_W-1:0] c_n;
      logic [CLAMP_W-1:0]        mag;
      drive_type                 d;
      lo_e = SPD_W'(lo);
      hi_e = $signed({{(SPD_W-SPEED_W){1'b0}}, hi});
      if (s < lo_e) begin
         c = lo_e;
      end else if (s > hi_e) begin
         c = hi_e;
      end else begin
         c = s;
      end
      c_n = CLAMP_W'(c);
      mag = c_n[CLAMP_W-1] ? CLAMP_W'(-c_n) : CLAMP_W'(c_n);
      d.reverse = c_n[CLAMP_W-1];
      d.duty    = (mag > CLAMP_W'(255)) ? {SPEED_W{1'b1}} : mag[SPEED_W-1:0];
      return d;
   endfunction

endpackage

FILE: rtl/core/lppd_front.sv
// ----------------------------------------------------------------------------
// lppd_front
// Takes sensor words, counts black sensors and forms 1000 * index sum.
// ----------------------------------------------------------------------------
module lppd_front import lppd_pkg::*; #(
   parameter  int SENSORS = SENSORS_DEF,
   localparam int SUM_MAX = SENSORS * (SENSORS - 1) / 2,
   localparam int CNT_W   = $clog2(SENSORS + 1),
   localparam int NUM_W   = $clog2(1000 * SUM_MAX + 1),
   localparam int ENTRY_W = NUM_W + CNT_W
) (
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [SENSORS-1:0]        req_sensor_levels,
   input  logic                      queue_full,
   output logic                      queue_push,
   output logic [ENTRY_W-1:0]        queue_data
);

   localparam int SUM_W   = $clog2(SUM_MAX + 1);

   logic [SUM_W-1:0] idx_sum;
   logic [CNT_W-1:0] black_cnt;
   logic [NUM_W-1:0] numerator;

   always_comb begin
      idx_sum   = '0;
      black_cnt = '0;
      for (int i = 0; i < SENSORS; i++) begin
         if (!req_sensor_levels[i]) begin
            idx_sum   = idx_sum + SUM_W'(i);
            black_cnt = black_cnt + CNT_W'(1);
         end
      end
   end

   assign numerator  = NUM_W'(idx_sum) * NUM_W'(1000);
   assign req_ready  = !queue_full;
   assign queue_push = req_valid && !queue_full;
   assign queue_data = {numerator, black_cnt};

endmodule

FILE: rtl/core/lppd_queue.sv
// ----------------------------------------------------------------------------
// lppd_queue
// Short FIFO between front and back.
// ----------------------------------------------------------------------------
module lppd_queue import lppd_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/lppd_div.sv
// ----------------------------------------------------------------------------
// lppd_div
// Restoring unsigned divider, DIV_BITS quotient bits per cycle.
// ----------------------------------------------------------------------------
module lppd_div import lppd_pkg::*; #(
   parameter int NUM_W = 14,
   parameter int DEN_W = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numerator,
   input  logic [DEN_W-1:0] denominator,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int STEPS  = (NUM_W + DIV_BITS - 1) / DIV_BITS;
   localparam int PAD_W  = STEPS * DIV_BITS;
   localparam int STEP_W = $clog2(STEPS + 1);

   logic [PAD_W-1:0]  dvd_ff, dvd_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;

   always_comb begin
      logic [DEN_W:0] trial;
      logic           qbit;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      for (int j = 0; j < DIV_BITS; j++) begin
         trial = {rem_in, dvd_in[PAD_W-1]};
         qbit  = (trial >= {1'b0, den_ff});
         if (qbit) begin
            trial = trial - {1'b0, den_ff};
         end
         rem_in = trial[DEN_W-1:0];
         dvd_in = {dvd_in[PAD_W-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= PAD_W'(numerator);
         rem_ff <= '0;
         den_ff <= denominator;
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff[NUM_W-1:0];

endmodule

FILE: rtl/core/lppd_back.sv
// ----------------------------------------------------------------------------
// lppd_back
// Position divide, PID update on a shared multiplier, motor drive output.
// ----------------------------------------------------------------------------
module lppd_back import lppd_pkg::*; #(
   parameter  int SENSORS = SENSORS_DEF,
   localparam int SUM_MAX = SENSORS * (SENSORS - 1) / 2,
   localparam int CNT_W   = $clog2(SENSORS + 1),
   localparam int NUM_W   = $clog2(1000 * SUM_MAX + 1),
   localparam int ENTRY_W = NUM_W + CNT_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 queue_empty,
   input  logic [ENTRY_W-1:0]   queue_data,
   output logic                 queue_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [POS_OUT_W-1:0] rsp_line_position,
   output logic                 rsp_left_reverse,
   output logic [SPEED_W-1:0]   rsp_left_duty,
   output logic                 rsp_right_reverse,
   output logic [SPEED_W-1:0]   rsp_right_duty
);

   localparam int CENTRE  = 500 * (SENSORS - 1);
   localparam int POS_W   = $clog2(1000 * (SENSORS - 1) + 1);

   back_state_type state_ff, state_in;

   logic [NUM_W-1:0]          quotient;
   logic                      div_done;
   logic                      div_start;
   logic                      zero_ff;
   logic [POS_W-1:0]          pos_ff;
   logic signed [ERR_W-1:0]   err_ff;
   logic signed [DERIV_W-1:0] deriv_ff;
   logic signed [INTEG_W-1:0] integral_ff;
   logic signed [PREV_W-1:0]  prev_ff;
   logic signed [MUL_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [CORR_W-1:0]  corr_ff;

   logic signed [POS_W:0]     err_wide;
   logic signed [ERR_W-1:0]   err_in;
   logic signed [MOP_W-1:0]   integ_sum;
   logic signed [INTEG_W-1:0] integ_in;
   logic signed [DERIV_W-1:0] deriv_in;
   logic signed [MOP_W-1:0]   op_a;
   logic [GAIN_W-1:0]         gain_sel;
   logic signed [ACC_W-1:0]   acc_adj;
   logic signed [SPD_W-1:0]   base_e, corr_e;
   drive_type                 left_drv, right_drv;
   logic                      slot_free;
   logic                      rsp_load;

   logic                      rsp_valid_ff;
   logic [POS_OUT_W-1:0]      rsp_pos_ff;
   drive_type                 rsp_left_ff, rsp_right_ff;

   lppd_div #(
      .NUM_W (NUM_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (queue_data[ENTRY_W-1:CNT_W]),
      .denominator (queue_data[CNT_W-1:0]),
      .done        (div_done),
      .quotient    (quotient)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_ERROR;
            end
         end
         ST_ERROR: state_in = ST_MUL_P;
         ST_MUL_P: state_in = ST_MUL_I;
         ST_MUL_I: state_in = ST_MUL_D;
         ST_MUL_D: state_in = ST_SUM;
         ST_SUM:   state_in = ST_CORR;
         ST_CORR:  state_in = ST_DRIVE;
         ST_DRIVE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      queue_pop = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      op_a      = MOP_W'(err_ff);
      gain_sel  = cfg.gain_prop;
      case (state_ff)
         ST_IDLE: begin
            queue_pop = !queue_empty;
            div_start = !queue_empty;
         end
         ST_MUL_I: begin
            op_a     = MOP_W'(integral_ff);
            gain_sel = cfg.gain_integ;
         end
         ST_MUL_D: begin
            op_a     = MOP_W'(deriv_ff);
            gain_sel = cfg.gain_deriv;
         end
         ST_DRIVE: rsp_load = slot_free;
         default: ;
      endcase
   end

   always_comb begin
      err_wide  = $signed({1'b0, POS_W'(CENTRE)}) - $signed({1'b0, pos_ff});
      err_in    = ERR_W'(err_wide);
      integ_sum = MOP_W'(integral_ff) + MOP_W'(err_in);
      if (integ_sum[MOP_W-1] != integ_sum[MOP_W-2]) begin
         integ_in = integ_sum[MOP_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                       : {1'b0, {(INTEG_W-1){1'b1}}};
      end else begin
         integ_in = integ_sum[INTEG_W-1:0];
      end
      deriv_in = DERIV_W'(err_in) - DERIV_W'(prev_ff);
      prod_in  = op_a * $signed({1'b0, gain_sel});
      acc_adj  = acc_ff + $signed({{(ACC_W-8){1'b0}}, {8{acc_ff[ACC_W-1]}}});
      base_e   = $signed({{(SPD_W-SPEED_W){1'b0}}, cfg.base_speed});
      corr_e   = SPD_W'(corr_ff);
      left_drv  = drive_split(base_e + corr_e, cfg.speed_floor, cfg.speed_ceiling);
      right_drv = drive_split(base_e - corr_e, cfg.speed_floor, cfg.speed_ceiling);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         integral_ff  <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_ERROR) begin
            integral_ff <= integ_in;
            prev_ff     <= err_in[PREV_W-1:0];
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         zero_ff <= (queue_data[CNT_W-1:0] == '0);
      end
      if (state_ff == ST_DIVIDE && div_done) begin
         pos_ff <= zero_ff ? POS_W'(CENTRE) : POS_W'(quotient);
      end
      if (state_ff == ST_ERROR) begin
         err_ff   <= err_in;
         deriv_ff <= deriv_in;
      end
      prod_ff <= prod_in;
      case (state_ff)
         ST_MUL_I: acc_ff <= ACC_W'(prod_ff);
         ST_MUL_D,
         ST_SUM:   acc_ff <= acc_ff + ACC_W'(prod_ff);
         ST_CORR:  corr_ff <= CORR_W'(acc_adj >>> 8);
         default: ;
      endcase
      if (rsp_load) begin
         rsp_pos_ff   <= POS_OUT_W'(pos_ff);
         rsp_left_ff  <= left_drv;
         rsp_right_ff <= right_drv;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_line_position = rsp_pos_ff;
   assign rsp_left_reverse  = rsp_left_ff.reverse;
   assign rsp_left_duty     = rsp_left_ff.duty;
   assign rsp_right_reverse = rsp_right_ff.reverse;
   assign rsp_right_duty    = rsp_right_ff.duty;

endmodule

FILE: rtl/core/line_position_pid_drive_core.sv
// STEPS = ceil(NUM_W / 4) divider iterations (4 for six sensors). The back end
// takes one sensor word at a time through the divider, then three products
// through one shared multiplier, before it pops the next; the front end keeps
// accepting words while the queue has room.
// Two queue slots and the output register absorb stalls on either side.
// Reset (synchronous): gains and limits to defaults, integral and previous error to zero.
// ----------------------------------------------------------------------------
// line_position_pid_drive_core
// Sensor row to line position, PID correction and two motor drive words.
// ----------------------------------------------------------------------------
module line_position_pid_drive_core import lppd_pkg::*; #(
   parameter int SENSORS = SENSORS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SENSORS-1:0]     req_sensor_levels,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [POS_OUT_W-1:0]   rsp_line_position,
   output logic                   rsp_left_reverse,
   output logic [SPEED_W-1:0]     rsp_left_duty,
   output logic                   rsp_right_reverse,
   output logic [SPEED_W-1:0]     rsp_right_duty,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int SUM_MAX = SENSORS * (SENSORS - 1) / 2;
   localparam int CNT_W   = $clog2(SENSORS + 1);
   localparam int NUM_W   = $clog2(1000 * SUM_MAX + 1);
   localparam int ENTRY_W = NUM_W + CNT_W;

   cfg_type              cfg_ff, cfg_in;
   logic                 queue_full, queue_empty, queue_push, queue_pop;
   logic [ENTRY_W-1:0]   push_data, pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_GAIN_PROP:     cfg_in.gain_prop     = csr_data;
            CSR_GAIN_INTEG:    cfg_in.gain_integ    = csr_data;
            CSR_GAIN_DERIV:    cfg_in.gain_deriv    = csr_data;
            CSR_BASE_SPEED:    cfg_in.base_speed    = csr_data[SPEED_W-1:0];
            CSR_SPEED_CEILING: cfg_in.speed_ceiling = csr_data[SPEED_W-1:0];
            CSR_SPEED_FLOOR:   cfg_in.speed_floor   = $signed(csr_data[FLOOR_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_prop     <= GAIN_PROP_RST;
         cfg_ff.gain_integ    <= GAIN_INTEG_RST;
         cfg_ff.gain_deriv    <= GAIN_DERIV_RST;
         cfg_ff.base_speed    <= BASE_RST;
         cfg_ff.speed_ceiling <= CEILING_RST;
         cfg_ff.speed_floor   <= FLOOR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lppd_front #(
      .SENSORS (SENSORS)
   ) u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sensor_levels (req_sensor_levels),
      .queue_full        (queue_full),
      .queue_push        (queue_push),
      .queue_data        (push_data)
   );

   lppd_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   lppd_back #(
      .SENSORS (SENSORS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .queue_empty       (queue_empty),
      .queue_data        (pop_data),
      .queue_pop         (queue_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_line_position (rsp_line_position),
      .rsp_left_reverse  (rsp_left_reverse),
      .rsp_left_duty     (rsp_left_duty),
      .rsp_right_reverse (rsp_right_reverse),
      .rsp_right_duty    (rsp_right_duty)
   );

endmodule

FILE: rtl/core/lppd_checker.sv
// ----------------------------------------------------------------------------
// lppd_checker
// Port-level checks on the line position PID drive core.
// ----------------------------------------------------------------------------
module lppd_checker import lppd_pkg::*; #(
   parameter int SENSORS = SENSORS_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [POS_OUT_W-1:0]   rsp_line_position,
   input logic                   rsp_left_reverse,
   input logic [SPEED_W-1:0]     rsp_left_duty,
   input logic                   rsp_right_reverse,
   input logic [SPEED_W-1:0]     rsp_right_duty
);

   localparam int POS_MAX = 1000 * (SENSORS - 1);

   logic [3:0] outst_ff, outst_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      outst_in = outst_ff;
      if (req_acc && !rsp_acc) begin
         outst_in = outst_ff + 4'd1;
      end else if (rsp_acc && !req_acc && outst_ff != 4'd0) begin
         outst_in = outst_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff <= '0;
      end else begin
         outst_ff <= outst_in;
      end
   end

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_line_position)
         && $stable(rsp_left_duty) && $stable(rsp_right_duty)
         && $stable(rsp_left_reverse) && $stable(rsp_right_reverse))
      else $error("result word changed while stalled");

   // a word out only for a word taken in
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outst_ff != 4'd0)
      else $error("result word without a sensor word");

   a_reverse_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_left_reverse || rsp_left_duty != '0)
         && (!rsp_right_reverse || rsp_right_duty != '0))
      else $error("reverse with zero duty");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (POS_MAX > 8191) || (int'(rsp_line_position) <= POS_MAX))
      else $error("line position out of range");

endmodule

bind line_position_pid_drive_core lppd_checker #(.SENSORS(SENSORS)) u_lppd_checker (.*);

FILE: tb/tb_line_position_pid_drive_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_position_pid_drive_core
// Self-checking bench for the line position PID drive core. Sensor words go
// in through bursts with random gaps, and drive words are compared field by
// field against a cycle-free model of the position, PID and clamp arithmetic.
// Coverage includes register writes between phases, limit extremes, a long
// output hold-off and integral wind-up towards each side.
// ----------------------------------------------------------------------------
module tb_line_position_pid_drive_core;
   import lppd_pkg::*;

   localparam int     NUM_SENSORS  = SENSORS_DEF;
   localparam longint LINE_CENTRE  = 500 * (NUM_SENSORS - 1);
   localparam longint INTEG_HI     = 8388607;
   localparam longint INTEG_LO     = -8388608;
   localparam int     DRAIN_CYCLES = 24;
   localparam int     LONG_HOLD    = 160;
   localparam int     PHASE_ITEMS  = 90;
   localparam int     SWING_ITEMS  = 20;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_7 = 3'd7;

   localparam logic [NUM_SENSORS-1:0] ALL_WHITE  = '1;
   localparam logic [NUM_SENSORS-1:0] ALL_BLACK  = '0;
   localparam logic [NUM_SENSORS-1:0] FAR_LEFT   = 6'b111110;
   localparam logic [NUM_SENSORS-1:0] FAR_RIGHT  = 6'b011111;

   typedef enum int {RX_ALWAYS, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_type;

   typedef struct packed {
      logic [POS_OUT_W-1:0] line_position;
      logic                 left_reverse;
      logic [SPEED_W-1:0]   left_duty;
      logic                 right_reverse;
      logic [SPEED_W-1:0]   right_duty;
   } drive_word_type;

   logic                   clock             = 1'b0;
   logic                   reset             = 1'b1;
   logic                   req_valid         = 1'b0;
   logic                   req_ready;
   logic [NUM_SENSORS-1:0] req_sensor_levels = '0;
   logic                   rsp_valid;
   logic                   rsp_ready         = 1'b0;
   logic [POS_OUT_W-1:0]   rsp_line_position;
   logic                   rsp_left_reverse;
   logic [SPEED_W-1:0]     rsp_left_duty;
   logic                   rsp_right_reverse;
   logic [SPEED_W-1:0]     rsp_right_duty;
   logic                   csr_valid         = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index         = '0;
   logic [CSR_DATA_W-1:0]  csr_data          = '0;

   // model copy of registers and loop state
   logic [GAIN_W-1:0]         cfg_gain_prop;
   logic [GAIN_W-1:0]         cfg_gain_integ;
   logic [GAIN_W-1:0]         cfg_gain_deriv;
   logic [SPEED_W-1:0]        cfg_base_speed;
   logic [SPEED_W-1:0]        cfg_ceiling;
   logic signed [FLOOR_W-1:0] cfg_floor;
   logic signed [INTEG_W-1:0] err_integral;
   logic signed [PREV_W-1:0]  last_error;

   drive_word_type expected_drive_q[$];
   int             error_count   = 0;
   rx_mode_type    ready_mode    = RX_ALWAYS;
   int             hold_requests = 0;
   int             hold_served   = 0;
   int             hold_left     = 0;
   int             ready_tick    = 0;

   line_position_pid_drive_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sensor_levels (req_sensor_levels),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_line_position (rsp_line_position),
      .rsp_left_reverse  (rsp_left_reverse),
      .rsp_left_duty     (rsp_left_duty),
      .rsp_right_reverse (rsp_right_reverse),
      .rsp_right_duty    (rsp_right_duty),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #1 clock = ~clock;

   initial begin
      #2_000_000;
      $display("tb_line_position_pid_drive_core failed");
      $finish;
   end

   // ---------------------------------------------------------------- model

   function automatic void model_reset();
      cfg_gain_prop  = GAIN_PROP_RST;
      cfg_gain_integ = GAIN_INTEG_RST;
      cfg_gain_deriv = GAIN_DERIV_RST;
      cfg_base_speed = BASE_RST;
      cfg_ceiling    = CEILING_RST;
      cfg_floor      = FLOOR_RST;
      err_integral   = '0;
      last_error     = '0;
   endfunction

   // clamp floor first, then ceiling; returns {reverse, duty}
   function automatic logic [SPEED_W:0] motor_drive(input longint s);
      longint lo, hi, c, mag;
      lo = cfg_floor;
      hi = cfg_ceiling;
      if (s < lo) begin
         c = lo;
      end else if (s > hi) begin
         c = hi;
      end else begin
         c = s;
      end
      mag = (c < 0) ? -c : c;
      if (mag > 255) begin
         mag = 255;
      end
      return {(c < 0), SPEED_W'(mag)};
   endfunction

   function automatic drive_word_type predict_drive(input logic [NUM_SENSORS-1:0] levels);
      longint idx_sum, black, pos, err, integ, deriv, acc, corr;
      longint kp, ki, kd, base;
      drive_word_type w;
      int i;
      idx_sum = 0;
      black   = 0;
      for (i = 0; i < NUM_SENSORS; i++) begin
         if (!levels[i]) begin
            idx_sum += i;
            black++;
         end
      end
      pos   = (black != 0) ? (idx_sum * 1000) / black : LINE_CENTRE;
      err   = LINE_CENTRE - pos;
      integ = longint'(err_integral) + err;
      if (integ > INTEG_HI) begin
         integ = INTEG_HI;
      end
      if (integ < INTEG_LO) begin
         integ = INTEG_LO;
      end
      deriv        = err - longint'(last_error);
      err_integral = INTEG_W'(integ);
      last_error   = PREV_W'(err);
      kp   = cfg_gain_prop;
      ki   = cfg_gain_integ;
      kd   = cfg_gain_deriv;
      base = cfg_base_speed;
      acc  = err * kp + integ * ki + deriv * kd;
      corr = acc / 256;
      w.line_position = POS_OUT_W'(pos);
      {w.left_reverse, w.left_duty}   = motor_drive(base + corr);
      {w.right_reverse, w.right_duty} = motor_drive(base - corr);
      return w;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_levels(input logic [NUM_SENSORS-1:0] levels);
      req_valid         <= 1'b1;
      req_sensor_levels <= levels;
      do @(posedge clock); while (!req_ready);
      expected_drive_q.push_back(predict_drive(levels));
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_drive_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0]  data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_GAIN_PROP:     cfg_gain_prop  = data;
         CSR_GAIN_INTEG:    cfg_gain_integ = data;
         CSR_GAIN_DERIV:    cfg_gain_deriv = data;
         CSR_BASE_SPEED:    cfg_base_speed = data[SPEED_W-1:0];
         CSR_SPEED_CEILING: cfg_ceiling    = data[SPEED_W-1:0];
         CSR_SPEED_FLOOR:   cfg_floor      = data[FLOOR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic csr_finish();
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // unused upper data bits are filled with noise; the block must drop them
   task automatic apply_config(input logic [GAIN_W-1:0]  kp, ki, kd,
                               input logic [SPEED_W-1:0] base, ceiling,
                               input logic [FLOOR_W-1:0] floor);
      csr_write(CSR_GAIN_PROP, kp);
      csr_write(CSR_GAIN_INTEG, ki);
      csr_write(CSR_GAIN_DERIV, kd);
      csr_write(CSR_BASE_SPEED, {8'($urandom), base});
      csr_write(CSR_SPEED_CEILING, {8'($urandom), ceiling});
      csr_write(CSR_SPEED_FLOOR, {7'($urandom), floor});
      csr_finish();
   endtask

   // half the samples a line under one or two adjacent sensors, else lost line, full row or noise
   function automatic logic [NUM_SENSORS-1:0] line_sample();
      logic [NUM_SENSORS-1:0] lv;
      int at;
      lv = ALL_WHITE;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            at = $urandom_range(0, NUM_SENSORS - 1);
            lv[at] = 1'b0;
            if ($urandom_range(0, 1) != 0 && at < NUM_SENSORS - 1) begin
               lv[at + 1] = 1'b0;
            end
         end
         5: lv = ALL_WHITE;
         6: lv = ALL_BLACK;
         default: lv = NUM_SENSORS'($urandom);
      endcase
      return lv;
   endfunction

   task automatic run_bursts(input int items, input int gap_max);
      int sent, burst;
      sent = 0;
      while (sent < items) begin
         burst = $urandom_range(1, 16);
         repeat (burst) begin
            if (sent < items) begin
               send_levels(line_sample());
               sent++;
            end
         end
         if (gap_max != 0 && sent < items && $urandom_range(0, 2) != 0) begin
            pause_sender($urandom_range(1, gap_max));
         end
      end
   endtask

   // ---------------------------------------------------------------- receiver

   always @(posedge clock) begin
      ready_tick <= ready_tick + 1;
      if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         hold_left   <= LONG_HOLD;
         rsp_ready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         case (ready_mode)
            RX_LIGHT:    rsp_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY:    rsp_ready <= ($urandom_range(0, 9) < 3);
            RX_PERIODIC: rsp_ready <= ((ready_tick % 7) < 4);
            default:     rsp_ready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      drive_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_drive_q.size() == 0) begin
            $error("unexpected drive word, line_position %0d", rsp_line_position);
            error_count++;
         end else begin
            want = expected_drive_q.pop_front();
            if (rsp_line_position !== want.line_position) begin
               $error("line_position: expected %0d, got %0d",
                      want.line_position, rsp_line_position);
               error_count++;
            end
            if (rsp_left_reverse !== want.left_reverse) begin
               $error("left_reverse: expected %0d, got %0d",
                      want.left_reverse, rsp_left_reverse);
               error_count++;
            end
            if (rsp_left_duty !== want.left_duty) begin
               $error("left_duty: expected %0d, got %0d", want.left_duty, rsp_left_duty);
               error_count++;
            end
            if (rsp_right_reverse !== want.right_reverse) begin
               $error("right_reverse: expected %0d, got %0d",
                      want.right_reverse, rsp_right_reverse);
               error_count++;
            end
            if (rsp_right_duty !== want.right_duty) begin
               $error("right_duty: expected %0d, got %0d", want.right_duty, rsp_right_duty);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // reset gains: lost line, full row, each sensor alone, truncated means
   task automatic check_position_cases();
      logic [NUM_SENSORS-1:0] lv;
      int i;
      ready_mode = RX_ALWAYS;
      send_levels(ALL_WHITE);
      send_levels(ALL_BLACK);
      for (i = 0; i < NUM_SENSORS; i++) begin
         lv    = ALL_WHITE;
         lv[i] = 1'b0;
         send_levels(lv);
      end
      send_levels(6'b111100);
      send_levels(6'b111000);
      send_levels(6'b110100);
      send_levels(6'b011110);
      send_levels(6'b101010);
      wait_drained();
   endtask

   // writes to unused indexes must leave every register alone
   task automatic check_spare_indexes();
      csr_write(CSR_SPARE_6, CSR_DATA_W'($urandom));
      csr_write(CSR_SPARE_7, CSR_DATA_W'($urandom));
      csr_finish();
      send_levels(FAR_LEFT);
      send_levels(6'b110011);
      send_levels(FAR_RIGHT);
      wait_drained();
   endtask

   task automatic check_gain_and_limit_extremes();
      apply_config('1, '1, '1, 8'd0, 8'd255, -9'sd255);
      send_levels(FAR_LEFT);
      send_levels(FAR_RIGHT);
      send_levels(ALL_WHITE);
      wait_drained();
      // zero gains: both motors run at base speed
      apply_config('0, '0, '0, 8'd200, 8'd255, -9'sd255);
      send_levels(FAR_LEFT);
      send_levels(ALL_BLACK);
      wait_drained();
      // reverse at full scale saturates the duty
      apply_config('1, '1, '1, 8'd0, 8'd0, 9'h100);
      send_levels(FAR_RIGHT);
      send_levels(FAR_LEFT);
      wait_drained();
      // floor above ceiling: below floor gives floor, anything else ceiling
      apply_config('0, '0, '0, 8'd60, 8'd20, 9'd100);
      send_levels(6'b111011);
      wait_drained();
      csr_write(CSR_BASE_SPEED, 16'd50);
      csr_finish();
      send_levels(6'b110111);
      wait_drained();
   endtask

   task automatic check_random_traffic();
      logic [GAIN_W-1:0]  g[3];
      logic [SPEED_W-1:0] base, ceiling;
      logic [FLOOR_W-1:0] floor;
      int phase, j;
      for (phase = 0; phase < 7; phase++) begin
         for (j = 0; j < 3; j++) begin
            case ($urandom_range(0, 5))
               0:       g[j] = '0;
               1:       g[j] = '1;
               default: g[j] = GAIN_W'($urandom_range(0, 1023));
            endcase
         end
         base    = ($urandom_range(0, 4) == 0) ? {SPEED_W{1'($urandom)}} : SPEED_W'($urandom);
         ceiling = ($urandom_range(0, 4) == 0) ? {SPEED_W{1'($urandom)}} : SPEED_W'($urandom);
         case ($urandom_range(0, 9))
            0:       floor = 9'h100;
            1:       floor = FLOOR_W'($urandom_range(1, 255));
            2:       floor = '0;
            3:       floor = -9'sd255;
            default: floor = FLOOR_W'(-int'($urandom_range(0, 255)));
         endcase
         if ($urandom_range(0, 2) == 0) begin
            csr_write($urandom_range(0, 1) ? CSR_SPARE_6 : CSR_SPARE_7, CSR_DATA_W'($urandom));
         end
         apply_config(g[0], g[1], g[2], base, ceiling, floor);
         if (phase == 1) begin
            // receiver holds off while the sender keeps pushing
            ready_mode = RX_ALWAYS;
            hold_requests++;
            run_bursts(PHASE_ITEMS, 0);
         end else if (phase == 0) begin
            ready_mode = RX_ALWAYS;
            run_bursts(PHASE_ITEMS, 0);
         end else begin
            ready_mode = rx_mode_type'($urandom_range(0, 3));
            run_bursts(PHASE_ITEMS, (phase % 2 == 0) ? 8 : 3);
         end
         wait_drained();
      end
   endtask

   // hold the line at each edge to wind the integral up both ways, then move on
   task automatic check_integral_swing();
      ready_mode = RX_ALWAYS;
      apply_config(16'd640, 16'd13, 16'd461, 8'd128, 8'd255, -9'sd150);
      repeat (SWING_ITEMS) send_levels(FAR_LEFT);
      repeat (SWING_ITEMS) send_levels(FAR_RIGHT);
      ready_mode = RX_LIGHT;
      run_bursts(20, 4);
      wait_drained();
   endtask

   initial begin
      model_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_position_cases();
      check_spare_indexes();
      check_gain_and_limit_extremes();
      check_random_traffic();
      check_integral_swing();
      if (error_count == 0 && expected_drive_q.size() == 0) begin
         $display("tb_line_position_pid_drive_core passed");
      end else begin
         $display("tb_line_position_pid_drive_core failed");
      end
      $finish;
   end

endmodule
